// ----- hdl/qbe_pkg.sv -----
// Shared types, constants and helper functions of the quadtree bitmap encoder.
`timescale 1ns / 1ps

package qbe_pkg;

  // Image geometry.
  localparam int MaxSide       = 64;
  localparam int MaxLog2       = $clog2(MaxSide);
  localparam int SideLog2W     = 3;
  localparam logic [SideLog2W-1:0] SideLog2Reset = 3'd6;

  localparam int CountW        = 2 * MaxLog2 + 1;
  localparam int LevelW        = $clog2(MaxLog2 + 1) > 0 ? $clog2(MaxLog2 + 1) : 1;
  localparam int PathW         = MaxLog2 > 0 ? MaxLog2 : 1;

  localparam int PixDepth      = (MaxSide * MaxSide) > 1 ? (MaxSide * MaxSide) : 2;
  localparam int PixAddrW      = $clog2(PixDepth);

  // One status entry per inner node of every pyramid level above the pixels.
  localparam int NodeDepth     = ((1 << (2 * MaxLog2)) - 1) / 3;
  localparam int NodeRamDepth  = NodeDepth > 1 ? NodeDepth : 2;
  localparam int NodeAddrW     = $clog2(NodeRamDepth);

  localparam int SymW          = 2;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic [SymW-1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_OPEN  = 2'd2,
    SYM_CLOSE = 2'd3
  } symbol_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_EMIT
  } state_e;

  // Uniformity status of one square.
  typedef struct packed {
    logic mixed;
    logic val;
  } node_t;

  typedef struct packed {
    logic load_start;
    logic ld_sel;
    logic ld_write;
    logic fetch_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ld_walk_needed;
    logic ld_last_level;
    logic out_free;
  } dp_status_t;

  // First node address of a pyramid level: levels are stored root first.
  function automatic logic [NodeAddrW-1:0] node_base(input logic [LevelW-1:0] lvl);
    logic [NodeAddrW-1:0] b;
    b = '0;
    for (int i = 0; i < MaxLog2; i++) begin
      if (LevelW'(i) < lvl) begin
        b = (b << 2) | NodeAddrW'(1);
      end
    end
    return b;
  endfunction

endpackage

// ----- hdl/qbe_in_if.sv -----
// Request channel of the quadtree bitmap encoder: load a pixel or fetch a symbol.
`timescale 1ns / 1ps

interface qbe_in_if;
  import qbe_pkg::*;

  logic valid;
  logic ready;
  logic mode;
  logic pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

// ----- hdl/qbe_out_if.sv -----
// Result channel of the quadtree bitmap encoder: one code symbol per fetch request.
`timescale 1ns / 1ps

interface qbe_out_if;
  import qbe_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            not_ready;

  modport source (output valid, output symbol, output last, output not_ready, input ready);
  modport sink   (input valid, input symbol, input last, input not_ready, output ready);
endinterface

// ----- hdl/qbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module qbe_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/qbe_ctrl.sv -----
// Sequencer of the quadtree bitmap encoder: request handshake and datapath commands.
`timescale 1ns / 1ps

module qbe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  input  qbe_pkg::dp_status_t status_i,
  output qbe_pkg::ctrl_cmd_t  cmd_o
);
  import qbe_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == MODE_FETCH) begin
            state_d = ST_EMIT;
          end else begin
            cmd_o.load_start = 1'b1;
            if (status_i.ld_walk_needed) begin
              state_d = ST_LOAD_RD;
            end
          end
        end
      end
      ST_LOAD_RD: begin
        cmd_o.ld_sel = 1'b1;
        state_d      = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd_o.ld_write = 1'b1;
        state_d        = status_i.ld_last_level ? ST_IDLE : ST_LOAD_RD;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.fetch_step = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/qbe_datapath.sv -----
// Datapath of the quadtree bitmap encoder: pixel and pyramid stores, traversal, result register.
`timescale 1ns / 1ps

module qbe_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qbe_pkg::SideLog2W-1:0] cfg_wdata_i,
  input  logic                          pixel_i,
  input  qbe_pkg::ctrl_cmd_t            cmd_i,
  output qbe_pkg::dp_status_t           status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [qbe_pkg::SymW-1:0]      out_symbol_o,
  output logic                          out_last_o,
  output logic                          out_not_ready_o
);
  import qbe_pkg::*;

  logic [SideLog2W-1:0] side_log2_q, side_log2_d;
  logic [CountW-1:0]    load_count_q, load_count_d;
  logic [LevelW-1:0]    ld_lvl_q, ld_lvl_d;
  logic                 pix_q;
  logic [LevelW-1:0]    level_q, level_d;
  logic [PathW-1:0]     row_path_q, row_path_d;
  logic [PathW-1:0]     col_path_q, col_path_d;
  logic                 phase_q, phase_d;
  logic                 finished_q, finished_d;
  logic                 out_valid_q, out_valid_d;
  logic [SymW-1:0]      out_symbol_q;
  logic                 out_last_q;
  logic                 out_not_ready_q;

  logic [LevelW-1:0]    eff_l;
  logic [CountW-1:0]    total;
  logic                 full;
  logic [PathW-1:0]     side_mask;

  logic [PathW-1:0]     ld_row, ld_col, ld_row_hi, ld_col_hi, ld_low_mask;
  logic [LevelW-1:0]    ld_sh;
  logic [PixAddrW-1:0]  ld_idx;
  logic [NodeAddrW-1:0] ld_addr;
  logic                 ld_first;
  node_t                ld_old, ld_new;

  logic [PixAddrW-1:0]  walk_idx;
  logic [NodeAddrW-1:0] walk_addr;
  logic [PixAddrW-1:0]  pix_raddr;
  logic [NodeAddrW-1:0] node_raddr;
  logic [$bits(node_t)-1:0] node_rdata;
  logic                 pix_rdata;
  node_t                rd_node;

  logic                 pix_we;
  logic [SymW-1:0]      res_sym;
  logic                 res_last, res_nr;
  logic                 do_adv, do_down;
  logic                 quad_is_last;

  // Effective side exponent, limited to the stored image size.
  always_comb begin
    if (int'(side_log2_q) > MaxLog2) begin
      eff_l = LevelW'(MaxLog2);
    end else begin
      eff_l = LevelW'(side_log2_q);
    end
  end

  assign total     = CountW'(1) << (2 * eff_l);
  assign full      = (load_count_q == total);
  assign side_mask = ~({PathW{1'b1}} << eff_l);

  // Pyramid update address for the pixel being loaded.
  assign ld_row      = PathW'(load_count_q >> eff_l);
  assign ld_col      = PathW'(load_count_q) & side_mask;
  assign ld_sh       = eff_l - ld_lvl_q;
  assign ld_row_hi   = ld_row >> ld_sh;
  assign ld_col_hi   = ld_col >> ld_sh;
  assign ld_idx      = (PixAddrW'(ld_row_hi) << ld_lvl_q) | PixAddrW'(ld_col_hi);
  assign ld_addr     = node_base(ld_lvl_q) + NodeAddrW'(ld_idx);
  assign ld_low_mask = ~({PathW{1'b1}} << ld_sh);
  assign ld_first    = (((ld_row | ld_col) & ld_low_mask) == '0);

  assign ld_old = node_t'(node_rdata);
  always_comb begin
    if (ld_first) begin
      ld_new.mixed = 1'b0;
      ld_new.val   = pix_q;
    end else begin
      ld_new.mixed = ld_old.mixed | (ld_old.val ^ pix_q);
      ld_new.val   = ld_old.val;
    end
  end

  // Traversal addresses of the current node.
  assign walk_idx   = (PixAddrW'(row_path_q) << level_q) | PixAddrW'(col_path_q);
  assign walk_addr  = node_base(level_q) + NodeAddrW'(walk_idx);
  assign pix_raddr  = (PixAddrW'(row_path_q) << eff_l) | PixAddrW'(col_path_q);
  assign node_raddr = cmd_i.ld_sel ? ld_addr : walk_addr;
  assign pix_we     = cmd_i.load_start && !full;

  qbe_ram #(
    .Width (1),
    .Depth (PixDepth)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (load_count_q[PixAddrW-1:0]),
    .wdata_i (pixel_i),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  qbe_ram #(
    .Width ($bits(node_t)),
    .Depth (NodeRamDepth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_write),
    .waddr_i (ld_addr),
    .wdata_i (ld_new),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  assign rd_node      = node_t'(node_rdata);
  assign quad_is_last = row_path_q[0] & col_path_q[0];

  // Symbol decision for one fetch.
  always_comb begin
    res_sym  = SYM_ZERO;
    res_last = 1'b0;
    res_nr   = 1'b0;
    do_adv   = 1'b0;
    do_down  = 1'b0;
    if (!full || finished_q) begin
      res_nr = 1'b1;
    end else if (phase_q) begin
      res_sym = SYM_CLOSE;
      do_adv  = 1'b1;
    end else if (level_q == eff_l) begin
      res_sym = pix_rdata ? SYM_ONE : SYM_ZERO;
      do_adv  = 1'b1;
    end else if (!rd_node.mixed) begin
      res_sym = rd_node.val ? SYM_ONE : SYM_ZERO;
      do_adv  = 1'b1;
    end else begin
      res_sym = SYM_OPEN;
      do_down = 1'b1;
    end
    if (do_adv && level_q == '0) begin
      res_last = 1'b1;
    end
  end

  // Next-state logic of the walk, the load counters and the result register.
  always_comb begin
    side_log2_d  = side_log2_q;
    load_count_d = load_count_q;
    ld_lvl_d     = ld_lvl_q;
    level_d      = level_q;
    row_path_d   = row_path_q;
    col_path_d   = col_path_q;
    phase_d      = phase_q;
    finished_d   = finished_q;
    out_valid_d  = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      side_log2_d  = cfg_wdata_i;
      load_count_d = '0;
      level_d      = '0;
      row_path_d   = '0;
      col_path_d   = '0;
      phase_d      = 1'b0;
      finished_d   = 1'b0;
    end else begin
      if (cmd_i.load_start) begin
        ld_lvl_d = '0;
        if (!full && eff_l == '0) begin
          load_count_d = load_count_q + CountW'(1);
        end
      end
      if (cmd_i.ld_write) begin
        if (status_o.ld_last_level) begin
          load_count_d = load_count_q + CountW'(1);
        end else begin
          ld_lvl_d = ld_lvl_q + LevelW'(1);
        end
      end
      if (cmd_i.fetch_step) begin
        out_valid_d = 1'b1;
        if (do_down) begin
          level_d    = level_q + LevelW'(1);
          row_path_d = row_path_q << 1;
          col_path_d = col_path_q << 1;
          phase_d    = 1'b0;
        end else if (do_adv) begin
          if (level_q == '0) begin
            finished_d = 1'b1;
          end else if (!quad_is_last) begin
            phase_d = 1'b0;
            if (!col_path_q[0]) begin
              col_path_d[0] = 1'b1;
            end else begin
              col_path_d[0] = 1'b0;
              row_path_d[0] = 1'b1;
            end
          end else begin
            level_d    = level_q - LevelW'(1);
            row_path_d = row_path_q >> 1;
            col_path_d = col_path_q >> 1;
            phase_d    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_log2_q  <= SideLog2Reset;
      load_count_q <= '0;
      ld_lvl_q     <= '0;
      level_q      <= '0;
      row_path_q   <= '0;
      col_path_q   <= '0;
      phase_q      <= 1'b0;
      finished_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      side_log2_q  <= side_log2_d;
      load_count_q <= load_count_d;
      ld_lvl_q     <= ld_lvl_d;
      level_q      <= level_d;
      row_path_q   <= row_path_d;
      col_path_q   <= col_path_d;
      phase_q      <= phase_d;
      finished_q   <= finished_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      pix_q <= pixel_i;
    end
    if (cmd_i.fetch_step) begin
      out_symbol_q    <= res_sym;
      out_last_q      <= res_last;
      out_not_ready_q <= res_nr;
    end
  end

  assign status_o.ld_walk_needed = !full && (eff_l != '0);
  assign status_o.ld_last_level  = (ld_lvl_q == eff_l - LevelW'(1));
  assign status_o.out_free       = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_symbol_o    = out_symbol_q;
  assign out_last_o      = out_last_q;
  assign out_not_ready_o = out_not_ready_q;

endmodule

// ----- hdl/quadtree_bitmap_encoder_core.sv -----
// Top level of the quadtree bitmap encoder: request and result channels, configuration.
`timescale 1ns / 1ps

// The encoder takes a square binary image of side 2^L, one pixel per load request
// in row-major order, and then returns its quadtree code one symbol per fetch
// request in preorder: a uniform square gives its pixel value, any other square an
// open bracket, its four quadrants (upper-left, upper-right, lower-left,
// lower-right) and a close bracket. L is the side_log2 register, limited to 6.
// Writing the register clears the loaded image and the walk, so a new image has
// to be loaded; a fetch before the image is complete, or after the last symbol,
// returns zero with not_ready set. In a load request the pixel is written to the
// pixel RAM and then every level of a uniformity pyramid gets a read-modify-write
// of its status RAM, one port access per cycle. A fetch request waits until the
// result register is free, and its symbol comes from the registered read of the
// node status or pixel RAM. The result sits in an output register, and the
// next request is taken while it waits. There is no clearing pass after reset.
module quadtree_bitmap_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qbe_in_if.sink                        in_i,
  qbe_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [qbe_pkg::SideLog2W-1:0] cfg_wdata_i
);
  import qbe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The sequencer owns the request handshake and steps the datapath.
  qbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the image, the pyramid, the walk state and the result.
  qbe_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pixel_i         (in_i.pixel),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_symbol_o    (out_o.symbol),
    .out_last_o      (out_o.last),
    .out_not_ready_o (out_o.not_ready)
  );

endmodule

// ----- hdl/qbe_checker.sv -----
// Port-level checks of the quadtree bitmap encoder and their bind to the top level.
`timescale 1ns / 1ps

module qbe_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_mode_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [qbe_pkg::SymW-1:0] out_symbol_i,
  input logic                     out_last_i,
  input logic                     out_not_ready_i
);
  import qbe_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_symbol_i)
      && $stable(out_last_i) && $stable(out_not_ready_i))
    else $error("result changed while stalled");

  // A refused fetch answers zero and never ends the code.
  a_nr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_not_ready_i |-> out_symbol_i == SYM_ZERO && !out_last_i)
    else $error("not_ready result carries a symbol");

  // A load request produces no result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i == MODE_LOAD && !out_valid_i |=> !out_valid_i)
    else $error("load request produced a result");

  // A fetch request into an empty result register is answered: it moves the sequencer to EMIT, which loads the result.
  a_fetch_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i == MODE_FETCH && !out_valid_i |-> ##2 out_valid_i)
    else $error("fetch request not answered");

endmodule

bind quadtree_bitmap_encoder_core qbe_checker u_qbe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_mode_i       (in_i.mode),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_symbol_i    (out_o.symbol),
  .out_last_i      (out_o.last),
  .out_not_ready_i (out_o.not_ready)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the quadtree bitmap encoder core.
`timescale 1ns / 1ps

// The testbench loads binary images through the request channel and fetches
// their quadtree codes back, one symbol per fetch request. A predictor that
// runs alongside the stimulus keeps its own copy of the pixel store and of the
// preorder walk. It works out the symbol that each accepted fetch request must
// return. Every symbol taken from the result channel is checked, field by
// field, against the oldest expected symbol.
//
// The run starts with a short directed table. The table covers the state after
// reset, the smallest image, fetches before the image is complete and after
// the code has ended, and loads into an image that is already full. Random
// phases follow. Each one writes the side register and loads a block-patterned
// image, sometimes with noise. It then walks the whole code, with a few broken
// sequences among them. The first random phase writes an oversized exponent
// and loads only the start of the largest image, so its fetches are refused.
// During the second phase the receiver holds off for a long stretch and the
// request channel has to back up.
module testbench;
  import qbe_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 8;
  // A load request reads and then writes every pyramid level, so the block can
  // stay busy after the last load has been accepted.
  localparam int unsigned DrainCycles = 2 * MaxLog2 + 8;
  localparam int unsigned HoldOff     = 300;
  localparam int unsigned RandomItems = 750;

  // One expected symbol on the result channel.
  typedef struct packed {
    symbol_e symbol;
    logic    last;
    logic    not_ready;
  } code_sym_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_FETCH
  } row_kind_e;

  // One row of the directed table. The value is the side exponent for a
  // register write and the pixel for a load. A typed symbol replaces the
  // prediction where the answer is plain from the spec.
  typedef struct packed {
    row_kind_e kind;
    logic [2:0] value;
    bit        has_typed;
    code_sym_t typed;
  } dir_row_t;

  localparam code_sym_t NotReadySym = '{SYM_ZERO, 1'b0, 1'b1};

  localparam int NumRows = 24;
  localparam dir_row_t DIRECTED [NumRows] = '{
    // After reset the side is 64, so neither fetch nor a single load completes.
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    '{ROW_LOAD,  3'd1, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    // A one-pixel image: nothing loaded yet, then a single digit that is last.
    '{ROW_CFG,   3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    '{ROW_LOAD,  3'd1, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, '{SYM_ONE, 1'b1, 1'b0}},
    // The code has ended. A further load into the full image is dropped.
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    '{ROW_LOAD,  3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    // A mixed 2x2 image, with a fetch in the middle of the load.
    '{ROW_CFG,   3'd1, 1'b0, NotReadySym},
    '{ROW_LOAD,  3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym},
    '{ROW_LOAD,  3'd1, 1'b0, NotReadySym},
    '{ROW_LOAD,  3'd1, 1'b0, NotReadySym},
    '{ROW_LOAD,  3'd0, 1'b0, NotReadySym},
    '{ROW_LOAD,  3'd1, 1'b0, NotReadySym},
    // Open bracket, four digits and the closing bracket come from the predictor.
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b0, NotReadySym},
    '{ROW_FETCH, 3'd0, 1'b1, NotReadySym}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SideLog2W-1:0] cfg_wdata_i;

  qbe_in_if  in_if ();
  qbe_out_if out_if ();

  quadtree_bitmap_encoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: the loaded image, the walk and the side register.
  logic                 img_mem [MaxSide * MaxSide];
  int unsigned          img_count;
  logic [1:0]           quad_path [0:MaxLog2];
  int unsigned          depth;
  bit                   close_next;
  bit                   code_done;
  logic [SideLog2W-1:0] side_cfg;

  code_sym_t   pending_symbols [$];
  int unsigned mismatches;
  int unsigned items_taken;

  // The driver sets calm for stretches without idling on either side. It sets
  // squeeze_now to ask the receiver for its long hold-off.
  bit calm;
  bit squeeze_now;

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  // Gap length shared by both sides: mostly none or short, now and then long.
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    if (calm) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned side_exponent();
    return (side_cfg > SideLog2W'(MaxLog2)) ? MaxLog2 : int'(side_cfg);
  endfunction

  function automatic void clear_image(input logic [SideLog2W-1:0] value);
    side_cfg   = value;
    img_count  = 0;
    depth      = 0;
    close_next = 1'b0;
    code_done  = 1'b0;
    for (int lv = 0; lv <= MaxLog2; lv++) begin
      quad_path[lv] = 2'd0;
    end
  endfunction

  // Completes the node that was just returned. The walk moves on to the next
  // sibling or, after the fourth quadrant, to the close bracket of the parent.
  // Completing the root ends the code, and the function returns 1.
  function automatic bit walk_next();
    if (depth == 0) begin
      code_done = 1'b1;
      return 1'b1;
    end
    if (quad_path[depth] != 2'd3) begin
      quad_path[depth] = quad_path[depth] + 2'd1;
      close_next = 1'b0;
    end else begin
      depth = depth - 1;
      close_next = 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to the predictor. The function returns 1
  // when the request causes a result, and sym then holds the expected symbol.
  // took is 0 for a load that the block drops because the image is full.
  function automatic bit quadtree_step(input mode_e m, input logic px,
                                       output code_sym_t sym, output bit took);
    int unsigned lg, side, total, size, row, col, s;
    logic first;
    bit uniform;
    lg    = side_exponent();
    side  = 1 << lg;
    total = side * side;
    sym   = NotReadySym;
    took  = 1'b1;
    if (m == MODE_LOAD) begin
      if (img_count < total) begin
        img_mem[img_count] = px;
        img_count++;
      end else begin
        took = 1'b0;
      end
      return 1'b0;
    end
    if (img_count < total || code_done) begin
      return 1'b1;
    end
    sym.not_ready = 1'b0;
    if (close_next) begin
      sym.symbol = SYM_CLOSE;
      sym.last   = walk_next();
      return 1'b1;
    end
    // Locate the square of the current node from the quadrant path.
    row = 0;
    col = 0;
    for (int lv = 1; lv <= depth; lv++) begin
      s = side >> lv;
      if (quad_path[lv][1]) row += s;
      if (quad_path[lv][0]) col += s;
    end
    size    = side >> depth;
    first   = img_mem[row * side + col];
    uniform = 1'b1;
    for (int r = 0; r < size && uniform; r++) begin
      for (int c = 0; c < size; c++) begin
        if (img_mem[(row + r) * side + col + c] !== first) begin
          uniform = 1'b0;
        end
      end
    end
    if (uniform || depth >= lg) begin
      sym.symbol = first ? SYM_ONE : SYM_ZERO;
      sym.last   = walk_next();
    end else begin
      sym.symbol       = SYM_OPEN;
      depth            = depth + 1;
      quad_path[depth] = 2'd0;
      close_next       = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("mismatch at %0t ns: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Offers one request after a random gap and holds it until it is accepted.
  // valid stays high when the next request follows without a gap, so it
  // gets only one assignment in that time step.
  task automatic send_request(input mode_e m, input logic px,
                              input bit has_typed, input code_sym_t typed);
    int unsigned gap;
    code_sym_t predicted;
    bit produced, took;
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.pixel <= px;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    produced = quadtree_step(m, px, predicted, took);
    if (took) items_taken++;
    if (produced) begin
      pending_symbols.insert(pending_symbols.size(), has_typed ? typed : predicted);
    end
  endtask

  task automatic fetch_symbol();
    send_request(MODE_FETCH, logic'($urandom_range(0, 1)), 1'b0, NotReadySym);
  endtask

  // The register is only written while the block is idle. Every result must
  // have arrived, and the load pipeline must have run dry.
  task automatic write_side(input logic [SideLog2W-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clear_image(value);
  endtask

  // Receiver: checks each accepted result and then chooses ready for the next
  // cycle. The long hold-off is counted here in cycles.
  initial begin
    int unsigned stall_left;
    bit squeezed;
    code_sym_t want;
    stall_left   = 0;
    squeezed     = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_symbols.size() == 0) begin
          report_mismatch($sformatf("result symbol %0d with nothing expected", out_if.symbol));
        end else begin
          want = pending_symbols.pop_front();
          if (out_if.symbol !== want.symbol) begin
            report_mismatch($sformatf("symbol %0d, expected %0d", out_if.symbol, want.symbol));
          end
          if (out_if.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", out_if.last, want.last));
          end
          if (out_if.not_ready !== want.not_ready) begin
            report_mismatch($sformatf("not_ready %0b, expected %0b",
                                      out_if.not_ready, want.not_ready));
          end
        end
      end
      if (squeeze_now && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = HoldOff;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = idle_cycles();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus: the directed table first, then random phases, one image each.
  initial begin
    logic blk [MaxSide * MaxSide];
    logic img [MaxSide * MaxSide];
    int unsigned lg, side, total, blk_log2, n_load, cut, fetched, start_items;
    int unsigned random_items, phase, style, pick;
    bit big, noisy;
    logic [SideLog2W-1:0] side_sel;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_if.valid <= 1'b0;
    in_if.mode  <= MODE_LOAD;
    in_if.pixel <= 1'b0;
    calm         = 1'b0;
    squeeze_now  = 1'b0;
    mismatches   = 0;
    items_taken  = 0;
    random_items = 0;
    clear_image(SideLog2Reset);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      case (DIRECTED[i].kind)
        ROW_CFG: begin
          write_side(DIRECTED[i].value);
        end
        ROW_LOAD: begin
          send_request(MODE_LOAD, DIRECTED[i].value[0], 1'b0, NotReadySym);
        end
        default: begin
          send_request(MODE_FETCH, logic'($urandom_range(0, 1)),
                       DIRECTED[i].has_typed, DIRECTED[i].typed);
        end
      endcase
    end

    phase = 0;
    while (random_items < RandomItems) begin
      // Phase zero writes the oversized exponent and loads only the start of
      // the largest image, so its fetches are refused. Later phases stay small
      // and keep the run short.
      big = (phase == 0);
      if (big) begin
        side_sel = 3'd7;
      end else begin
        pick = $urandom_range(0, 9);
        side_sel = (pick < 2) ? 3'd0 : (pick < 4) ? 3'd1 : (pick < 7) ? 3'd2 :
                   (pick < 9) ? 3'd3 : 3'd4;
      end
      calm = big || ($urandom_range(0, 4) == 0);
      write_side(side_sel);
      start_items = items_taken;
      lg    = side_exponent();
      side  = 1 << lg;
      total = side * side;

      // A random block pattern gives both uniform and mixed squares at every
      // depth. Scattered noise pixels push parts of the walk to full depth.
      blk_log2 = big ? 3 : $urandom_range(0, lg);
      noisy    = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < MaxSide * MaxSide; k++) begin
        blk[k] = logic'($urandom_range(0, 1));
      end
      for (int k = 0; k < total; k++) begin
        img[k] = blk[(((k >> lg) >> blk_log2) << MaxLog2) | ((k % side) >> blk_log2)];
        if (noisy && $urandom_range(0, big ? 255 : 31) == 0) img[k] = ~img[k];
      end

      // style 0 is a broken load that stops short of a full image, and style 1
      // cuts the code walk off early. Every other style is a complete sequence.
      style  = big ? 0 : (phase == 1) ? 5 : $urandom_range(0, 9);
      n_load = big ? $urandom_range(1, 64) :
               (style == 0) ? $urandom_range(0, total - 1) : total;
      for (int k = 0; k < n_load; k++) begin
        if ($urandom_range(0, 7) == 0) fetch_symbol();
        send_request(MODE_LOAD, img[k], 1'b0, NotReadySym);
      end
      if (style == 0) begin
        repeat ($urandom_range(1, 3)) fetch_symbol();
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_request(MODE_LOAD, logic'($urandom_range(0, 1)), 1'b0, NotReadySym);
          end
        end
        // The receiver starts its hold-off while these fetches keep coming, so
        // the result register fills and the request channel backs up.
        if (phase == 1) begin
          squeeze_now = 1'b1;
          repeat (4) fetch_symbol();
        end
        cut     = (style == 1) ? $urandom_range(1, 6) : 0;
        fetched = 0;
        while (!code_done && (cut == 0 || fetched < cut)) begin
          fetch_symbol();
          fetched++;
        end
        repeat ($urandom_range(0, 2)) fetch_symbol();
      end
      random_items += items_taken - start_items;
      phase++;
    end

    in_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog. The worst case is a few thousand requests, each waiting out a
  // long gap and a long stall, and this limit is several times that.
  initial begin
    #(40_000_000);
    $display("testbench failed");
    $finish;
  end

endmodule
